/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the one RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define CSPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define CSPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/cspu_pkg.sv */
// ----------------------------------------------------------------------------
// Cardinal spline upsampler package
// Widths, types, the Hermite weight table and the sequencer states.
// ----------------------------------------------------------------------------
package cspu_pkg;

  localparam int MAX_POINTS = 64;
  localparam int STEPS      = 15;

  localparam int FRAC_BITS  = 15;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
  localparam int SCALE_RESET = 8192;

  localparam int SEG_CAP = ((MAX_POINTS - 2) > 63) ? 63 : (MAX_POINTS - 2);
  localparam int SEG_COUNT_MAX = 127;

  localparam int STEP_W = $clog2(STEPS + 1);

  localparam longint DIVS   = STEPS + 1;
  localparam longint DIVS3  = DIVS * DIVS * DIVS;
  localparam longint TWO_D3 = 2 * DIVS3;

  typedef logic signed [15:0] knot_t;
  typedef logic signed [16:0] diff_t;
  typedef logic signed [17:0] op_t;
  typedef logic signed [35:0] prod_t;
  typedef logic signed [39:0] acc_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [6:0]         seg_count_t;

  localparam step_t STEP_LAST = step_t'(STEPS);

  typedef op_t [3:0]             weight_set_t;
  typedef weight_set_t [STEPS:0] weight_rom_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clear;
    logic acc_en;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAN_MUL,
    ST_TAN_RND,
    ST_SEG_KNOT,
    ST_PT_MUL,
    ST_PT_ACC,
    ST_PT_RND,
    ST_SEG_DONE,
    ST_FINAL
  } state_t;

  // Rounds num * 2^15 / D^3 to nearest with halves going up.
  function automatic op_t round_weight(input longint num);
    longint x;
    longint q;
    x = 2 * num * 32768 + DIVS3;
    q = x / TWO_D3;
    if ((x < 0) && ((x % TWO_D3) != 0)) begin
      q = q - 1;
    end
    return op_t'(q);
  endfunction

  // Cubic Hermite weights h00, h01, h10, h11 for u = j / (STEPS + 1).
  function automatic weight_rom_t build_weights();
    weight_rom_t rom;
    longint j1;
    longint j2;
    longint j3;
    rom = '0;
    for (int j = 1; j <= STEPS; j++) begin
      j1 = longint'(j);
      j2 = j1 * j1;
      j3 = j2 * j1;
      rom[j][0] = round_weight(2 * j3 - 3 * j2 * DIVS + DIVS3);
      rom[j][1] = round_weight(-2 * j3 + 3 * j2 * DIVS);
      rom[j][2] = round_weight(j3 - 2 * j2 * DIVS + j1 * DIVS * DIVS);
      rom[j][3] = round_weight(j3 - j2 * DIVS);
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weights();

  function automatic logic [5:0] seg_number(input seg_count_t count);
    if (count < seg_count_t'(SEG_CAP)) begin
      return count[5:0];
    end
    return 6'(SEG_CAP);
  endfunction

endpackage

/* hdl/cardinal_spline_upsampler.sv */
// ----------------------------------------------------------------------------
// Cardinal spline upsampler
// Sequencing: a frame's first bar only stores a knot; its second stalls the input while the
//   first tangent is formed; each later bar forms a tangent and one segment, plus output stalls.
// A frame-ending bar other than a frame's first adds the closing segment and the final knot.
// Each curve point takes four multiplies, an accumulate and a rounding; a new bar is taken only in ST_IDLE.
// Reset (synchronous, rst high) clears the frame and sets tangent_scale to 8192.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cardinal_spline_upsampler (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               bar_valid,
  output logic               bar_stall,
  input  logic [15:0]        bar_height,
  input  logic               frame_end,
  output logic               point_valid,
  input  logic               point_stall,
  output logic [5:0]         segment_index,
  output logic [3:0]         step_index,
  output logic signed [15:0] curve_value,
  output logic               run_end
);

  cspu_pkg::state_t state, state_next;

  logic [15:0] tangent_scale;

  cspu_pkg::knot_t      older_knot, older_knot_next;
  cspu_pkg::knot_t      newer_knot, newer_knot_next;
  cspu_pkg::knot_t      cur_knot, cur_knot_next;
  cspu_pkg::op_t        older_tangent, older_tangent_next;
  cspu_pkg::op_t        new_tangent, new_tangent_next;
  cspu_pkg::diff_t      diff, diff_next;
  logic [1:0]           knots_seen, knots_seen_next;
  cspu_pkg::seg_count_t seg_count, seg_count_next;
  cspu_pkg::step_t      step, step_next;
  logic [1:0]           term, term_next;
  logic                 last_bar, last_bar_next;
  logic                 tan_first, tan_first_next;
  logic                 end_phase, end_phase_next;

  logic                 emit;
  logic [5:0]           emit_seg;
  logic [3:0]           emit_step;
  cspu_pkg::knot_t      emit_value;
  logic                 emit_last;

  cspu_pkg::mac_ctl_t   mac_ctl;
  cspu_pkg::op_t        mac_a, mac_b;
  cspu_pkg::op_t        mac_tangent;
  cspu_pkg::knot_t      mac_point;

  cspu_pkg::knot_t      bar_knot;
  logic                 accept;
  logic                 out_free;

  cspu_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .op_a    (mac_a),
    .op_b    (mac_b),
    .tangent (mac_tangent),
    .point   (mac_point)
  );

  assign cfg_ready = 1'b1;
  assign bar_stall = (state != cspu_pkg::ST_IDLE);
  assign accept    = bar_valid && !bar_stall;
  assign out_free  = !point_valid || !point_stall;

  // Recentring h - 32768 is a flip of the top bit.
  assign bar_knot = cspu_pkg::knot_t'({~bar_height[15], bar_height[14:0]});

  always_comb begin
    state_next         = state;
    older_knot_next    = older_knot;
    newer_knot_next    = newer_knot;
    cur_knot_next      = cur_knot;
    older_tangent_next = older_tangent;
    new_tangent_next   = new_tangent;
    diff_next          = diff;
    knots_seen_next    = knots_seen;
    seg_count_next     = seg_count;
    step_next          = step;
    term_next          = term;
    last_bar_next      = last_bar;
    tan_first_next     = tan_first;
    end_phase_next     = end_phase;
    emit               = 1'b0;
    emit_seg           = cspu_pkg::seg_number(seg_count);
    emit_step          = 4'(step);
    emit_value         = mac_point;
    emit_last          = 1'b0;
    mac_ctl            = '0;
    mac_a              = '0;
    mac_b              = '0;

    unique case (state)
      cspu_pkg::ST_IDLE: begin
        if (accept) begin
          cur_knot_next  = bar_knot;
          last_bar_next  = frame_end;
          end_phase_next = 1'b0;
          priority if (knots_seen == 2'd0) begin
            newer_knot_next = bar_knot;
            knots_seen_next = frame_end ? 2'd0 : 2'd1;
          end else if (knots_seen == 2'd1) begin
            older_knot_next = newer_knot;
            newer_knot_next = bar_knot;
            knots_seen_next = 2'd2;
            diff_next       = cspu_pkg::diff_t'(bar_knot) - cspu_pkg::diff_t'(newer_knot);
            tan_first_next  = 1'b1;
            state_next      = cspu_pkg::ST_TAN_MUL;
          end else begin
            diff_next       = cspu_pkg::diff_t'(bar_knot) - cspu_pkg::diff_t'(older_knot);
            tan_first_next  = 1'b0;
            state_next      = cspu_pkg::ST_TAN_MUL;
          end
        end
      end
      cspu_pkg::ST_TAN_MUL: begin
        mac_a          = cspu_pkg::op_t'(diff);
        mac_b          = cspu_pkg::op_t'({2'b00, tangent_scale});
        mac_ctl.mul_en = 1'b1;
        state_next     = cspu_pkg::ST_TAN_RND;
      end
      cspu_pkg::ST_TAN_RND: begin
        if (tan_first) begin
          older_tangent_next = mac_tangent;
          if (last_bar) begin
            // A two-bar frame: the end tangent is the same one-sided difference.
            diff_next      = cspu_pkg::diff_t'(newer_knot) - cspu_pkg::diff_t'(older_knot);
            tan_first_next = 1'b0;
            end_phase_next = 1'b1;
            state_next     = cspu_pkg::ST_TAN_MUL;
          end else begin
            state_next = cspu_pkg::ST_IDLE;
          end
        end else begin
          new_tangent_next = mac_tangent;
          state_next       = cspu_pkg::ST_SEG_KNOT;
        end
      end
      cspu_pkg::ST_SEG_KNOT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_step  = 4'd0;
          emit_value = older_knot;
          step_next  = cspu_pkg::step_t'(1);
          term_next  = 2'd0;
          state_next = cspu_pkg::ST_PT_MUL;
        end
      end
      cspu_pkg::ST_PT_MUL: begin
        unique case (term)
          2'd0: mac_a = cspu_pkg::op_t'(older_knot);
          2'd1: mac_a = cspu_pkg::op_t'(newer_knot);
          2'd2: mac_a = older_tangent;
          2'd3: mac_a = new_tangent;
          default: mac_a = '0;
        endcase
        mac_b             = cspu_pkg::op_t'(cspu_pkg::WEIGHT_ROM[step][term]);
        mac_ctl.mul_en    = 1'b1;
        mac_ctl.acc_clear = (term == 2'd0);
        mac_ctl.acc_en    = (term != 2'd0);
        term_next         = term + 2'd1;
        if (term == 2'd3) begin
          state_next = cspu_pkg::ST_PT_ACC;
        end
      end
      cspu_pkg::ST_PT_ACC: begin
        mac_ctl.acc_en = 1'b1;
        state_next     = cspu_pkg::ST_PT_RND;
      end
      cspu_pkg::ST_PT_RND: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = (step == cspu_pkg::STEP_LAST) && !last_bar;
          if (step == cspu_pkg::STEP_LAST) begin
            state_next = cspu_pkg::ST_SEG_DONE;
          end else begin
            step_next  = step + cspu_pkg::step_t'(1);
            term_next  = 2'd0;
            state_next = cspu_pkg::ST_PT_MUL;
          end
        end
      end
      cspu_pkg::ST_SEG_DONE: begin
        if (seg_count != cspu_pkg::seg_count_t'(cspu_pkg::SEG_COUNT_MAX)) begin
          seg_count_next = seg_count + cspu_pkg::seg_count_t'(1);
        end
        if (end_phase) begin
          state_next = cspu_pkg::ST_FINAL;
        end else begin
          older_knot_next    = newer_knot;
          newer_knot_next    = cur_knot;
          older_tangent_next = new_tangent;
          if (last_bar) begin
            diff_next      = cspu_pkg::diff_t'(cur_knot) - cspu_pkg::diff_t'(newer_knot);
            tan_first_next = 1'b0;
            end_phase_next = 1'b1;
            state_next     = cspu_pkg::ST_TAN_MUL;
          end else begin
            state_next = cspu_pkg::ST_IDLE;
          end
        end
      end
      cspu_pkg::ST_FINAL: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_seg           = cspu_pkg::seg_number(seg_count - cspu_pkg::seg_count_t'(1));
          emit_step          = 4'd0;
          emit_value         = newer_knot;
          emit_last          = 1'b1;
          older_knot_next    = '0;
          newer_knot_next    = '0;
          older_tangent_next = '0;
          knots_seen_next    = 2'd0;
          seg_count_next     = '0;
          state_next         = cspu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cspu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cspu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tangent_scale <= 16'(cspu_pkg::SCALE_RESET);
      older_knot    <= '0;
      newer_knot    <= '0;
      older_tangent <= '0;
      knots_seen    <= 2'd0;
      seg_count     <= '0;
      point_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tangent_scale <= cfg_data;
      end
      older_knot    <= older_knot_next;
      newer_knot    <= newer_knot_next;
      older_tangent <= older_tangent_next;
      knots_seen    <= knots_seen_next;
      seg_count     <= seg_count_next;
      point_valid   <= emit || (point_valid && point_stall);
    end
  end

  always_ff @(posedge clk) begin
    cur_knot    <= cur_knot_next;
    new_tangent <= new_tangent_next;
    diff        <= diff_next;
    step        <= step_next;
    term        <= term_next;
    last_bar    <= last_bar_next;
    tan_first   <= tan_first_next;
    end_phase   <= end_phase_next;
    if (emit) begin
      segment_index <= emit_seg;
      step_index    <= emit_step;
      curve_value   <= emit_value;
      run_end       <= emit_last;
    end
  end

  // A word is only produced into an empty or draining output register.
  `CSPU_ASSERT(a_no_overwrite, !(emit && point_valid && point_stall), "output word overwritten")
  // Any bar after the first of a frame keeps the sequencer busy.
  `CSPU_ASSERT_NEXT(a_busy_after_bar, accept && (knots_seen != 2'd0), bar_stall, "bar not processed")
  // The final knot always follows at least one segment of its frame.
  `CSPU_ASSERT(a_final_has_seg, (state != cspu_pkg::ST_FINAL) || (seg_count != '0), "final knot without segment")
  // Point steps stay within one segment.
  `CSPU_ASSERT(a_step_range, (state != cspu_pkg::ST_PT_MUL) || ((step != '0) && (step <= cspu_pkg::STEP_LAST)), "step out of range")

endmodule

/* hdl/cspu_mac.sv */
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One registered 18x18 multiplier feeding an accumulator, with the rounding
// of tangents and the rounding and saturation of curve points.
// ----------------------------------------------------------------------------
module cspu_mac (
  input  logic              clk,
  input  cspu_pkg::mac_ctl_t ctl,
  input  cspu_pkg::op_t     op_a,
  input  cspu_pkg::op_t     op_b,
  output cspu_pkg::op_t     tangent,
  output cspu_pkg::knot_t   point
);

  cspu_pkg::prod_t prod;
  cspu_pkg::acc_t  acc;
  cspu_pkg::prod_t prod_rnd;
  cspu_pkg::acc_t  acc_rnd;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= cspu_pkg::prod_t'(op_a) * cspu_pkg::prod_t'(op_b);
    end
    if (ctl.acc_clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + cspu_pkg::acc_t'(prod);
    end
  end

  // Arithmetic shifts give floor, so adding a half first rounds half up.
  assign prod_rnd = (prod + cspu_pkg::prod_t'(cspu_pkg::ROUND_HALF)) >>> cspu_pkg::FRAC_BITS;
  assign acc_rnd  = (acc + cspu_pkg::acc_t'(cspu_pkg::ROUND_HALF)) >>> cspu_pkg::FRAC_BITS;

  assign tangent = cspu_pkg::op_t'(prod_rnd);

  always_comb begin
    if (acc_rnd > cspu_pkg::acc_t'(32767)) begin
      point = 16'sh7fff;
    end else if (acc_rnd < -cspu_pkg::acc_t'(32768)) begin
      point = 16'sh8000;
    end else begin
      point = cspu_pkg::knot_t'(acc_rnd);
    end
  end

endmodule
